/* rtl/core/c8_pkg.sv */
// ----------------------------------------------------------------------------
// CHIP-8 core package
// Shared types, codes, the hex font and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package c8_pkg;

	// Sizes of the main memory and the display store.
	localparam int MEM_BYTES = 4096;
	localparam int ADDR_W    = $clog2(MEM_BYTES);
	localparam int SCREEN_W  = 64;
	localparam int SCREEN_H  = 32;
	localparam int FB_BYTES  = (SCREEN_W / 8) * SCREEN_H;
	localparam int FB_AW     = $clog2(FB_BYTES);
	localparam int FONT_LEN  = 80;

	// Reset values.
	localparam logic [ADDR_W-1:0] PC_RESET  = 12'h200;
	localparam logic [ADDR_W-1:0] SP_RESET  = 12'hF00;
	localparam logic [7:0]        JUMP_BYTE = 8'h12;

	// Function codes of an input word.
	localparam logic [2:0] FN_EXEC   = 3'd0;
	localparam logic [2:0] FN_TICK   = 3'd1;
	localparam logic [2:0] FN_KEYDN  = 3'd2;
	localparam logic [2:0] FN_KEYUP  = 3'd3;
	localparam logic [2:0] FN_MEMWR  = 3'd4;
	localparam logic [2:0] FN_DISPRD = 3'd5;

	// Whole opcodes and sub-codes.
	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;
	localparam logic [7:0]  NN_SKP  = 8'h9E;
	localparam logic [7:0]  NN_SKNP = 8'hA1;
	localparam logic [7:0]  NN_GDT  = 8'h07;
	localparam logic [7:0]  NN_WKEY = 8'h0A;
	localparam logic [7:0]  NN_SDT  = 8'h15;
	localparam logic [7:0]  NN_SST  = 8'h18;
	localparam logic [7:0]  NN_ADDI = 8'h1E;
	localparam logic [7:0]  NN_FONT = 8'h29;
	localparam logic [7:0]  NN_BCD  = 8'h33;
	localparam logic [7:0]  NN_STR  = 8'h55;
	localparam logic [7:0]  NN_LDR  = 8'h65;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [3:0] REG_VF = 4'hF;

	// Hex font, five bytes per digit.
	localparam logic [7:0] FONT [0:FONT_LEN-1] = '{
		8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
		8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
		8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
		8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
	};

	// Request to the main memory: one port, read always at addr.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	// Request to the display store.
	typedef struct packed {
		logic             we;
		logic             clear;
		logic [FB_AW-1:0] waddr;
		logic [7:0]       wdata;
		logic [FB_AW-1:0] raddr;
	} fb_req_t;

	// Request to the register file.
	typedef struct packed {
		logic       we;
		logic [3:0] waddr;
		logic [7:0] wdata;
		logic [3:0] raddr;
	} rf_req_t;

	// Power-on contents of one main memory byte.
	function automatic logic [7:0] mem_init_byte(input logic [ADDR_W-1:0] a);
		logic [7:0] b;
		b = '0;
		if (a < ADDR_W'(FONT_LEN)) begin
			b = FONT[a[6:0]];
		end else if (a == PC_RESET) begin
			b = JUMP_BYTE;
		end
		return b;
	endfunction

	// Mirror a byte so that the leftmost sprite pixel lands in bit 0.
	function automatic logic [7:0] bit_rev(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[k] = v[7-k];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/c8_mem.sv */
// ----------------------------------------------------------------------------
// CHIP-8 main memory
// Single-port synchronous RAM with a power-on fill pass for font and jump.
// ----------------------------------------------------------------------------
`default_nettype none

module c8_mem (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire c8_pkg::mem_req_t   req,
	output logic [7:0]              rdata,
	output logic                    ready
);

	logic [7:0]               mem [0:c8_pkg::MEM_BYTES-1];
	logic [c8_pkg::ADDR_W:0]  init_cnt_q;
	logic [7:0]               rdata_q;

	assign ready = init_cnt_q[c8_pkg::ADDR_W];
	assign rdata = rdata_q;

	// The fill counter walks every address once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
		end else if (!ready) begin
			init_cnt_q <= init_cnt_q + 1'b1;
		end
	end

	// Storage: fill writes first, then normal writes; read data registered.
	always_ff @(posedge clk) begin
		if (!ready) begin
			mem[init_cnt_q[c8_pkg::ADDR_W-1:0]] <=
				c8_pkg::mem_init_byte(init_cnt_q[c8_pkg::ADDR_W-1:0]);
		end else if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

endmodule

`default_nettype wire

/* rtl/core/c8_fb.sv */
// ----------------------------------------------------------------------------
// CHIP-8 display store
// 256-byte pixel memory with per-byte valid bits for reset and screen clear.
// ----------------------------------------------------------------------------
`default_nettype none

module c8_fb (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire c8_pkg::fb_req_t   req,
	output logic [7:0]             rdata
);

	logic [7:0]                   mem [0:c8_pkg::FB_BYTES-1];
	logic [c8_pkg::FB_BYTES-1:0]  vld_q;
	logic [7:0]                   rdata_q;

	assign rdata = rdata_q;

	// Valid bits: cleared at once by reset or a screen clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clear) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	// Storage; a byte that is not valid reads as dark.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= vld_q[req.raddr] ? mem[req.raddr] : 8'h00;
	end

endmodule

`default_nettype wire

/* rtl/core/c8_rf.sv */
// ----------------------------------------------------------------------------
// CHIP-8 register file
// Sixteen 8-bit V registers, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module c8_rf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire c8_pkg::rf_req_t   req,
	output logic [7:0]             rdata
);

	logic [7:0] regs_q [0:15];
	logic [7:0] rdata_q;

	assign rdata = rdata_q;

	// Registers clear on reset; read data is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) begin
				regs_q[k] <= '0;
			end
			rdata_q <= '0;
		end else begin
			if (req.we) begin
				regs_q[req.waddr] <= req.wdata;
			end
			rdata_q <= regs_q[req.raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/chip8_interpreter_core.sv */
// ----------------------------------------------------------------------------
// CHIP-8 interpreter core
// Sequencer around the main memory, display store and register file.
// ----------------------------------------------------------------------------
// Timing: timer, key, memory write and idle words give their result in the
// cycle after acceptance; a display read passes through S_FBRD first. An
// instruction runs through fetch (S_F1, S_F2), register reads (S_RX, S_RY)
// and S_EX; calls, returns, flag-setting ALU operations, draws, decimal splits
// and block copies take further states, all set by the one memory port.
// One word is in flight at a time; done is a one-cycle strobe.
// After reset busy stays high while the memory is filled.
`default_nettype none

module chip8_interpreter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  func,
	input  wire logic [3:0]  key_index,
	input  wire logic [11:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic [7:0]  random_byte,
	output logic             done,
	output logic [11:0]      program_counter,
	output logic [7:0]       read_data,
	output logic             sound_on,
	output logic             key_wait
);

	typedef enum logic [21:0] {
		S_IDLE  = 22'h000001,
		S_FBRD  = 22'h000002,
		S_F1    = 22'h000004,
		S_F2    = 22'h000008,
		S_RX    = 22'h000010,
		S_RY    = 22'h000020,
		S_EX    = 22'h000040,
		S_RET1  = 22'h000080,
		S_RET2  = 22'h000100,
		S_CALL  = 22'h000200,
		S_FLAG  = 22'h000400,
		S_DMEM  = 22'h000800,
		S_DLINE = 22'h001000,
		S_DB0   = 22'h002000,
		S_DB1   = 22'h004000,
		S_BCD1  = 22'h008000,
		S_BCD2  = 22'h010000,
		S_ST0   = 22'h020000,
		S_ST1   = 22'h040000,
		S_LD0   = 22'h080000,
		S_LD1   = 22'h100000,
		S_RESP  = 22'h200000
	} state_t;

	state_t           state_q;
	logic [11:0]      pc_q, i_q, sp_q;
	logic [7:0]       dt_q, st_q;
	logic [15:0]      keys_q;
	logic [4:0]       wait_q;
	logic [3:0]       cnt_q;

	logic [15:0]      op_q;
	logic [7:0]       vx_q, vy_q, rd_q, rnd_q;
	logic [15:0]      spr_q;
	logic             flag_q, hit_q;
	logic [6:0]       rem_q;
	logic [3:0]       ret_hi_q;

	c8_pkg::mem_req_t mem_req;
	c8_pkg::fb_req_t  fb_req;
	c8_pkg::rf_req_t  rf_req;
	logic [7:0]       mem_rdata, fb_rdata, rf_rdata;
	logic             mem_ready;

	logic             accept;
	logic [3:0]       nib, opx, opy, opn;
	logic [7:0]       nn;
	logic [11:0]       nnn;
	logic [4:0]       py;
	logic [2:0]       col0, col1;
	logic [7:0]       fb_a0, fb_a1;
	logic [11:0]      i_cnt;
	logic             skip;
	logic [11:0]      pc_next;
	logic [7:0]       alu_res;
	logic             alu_flag, alu_we;
	logic [8:0]       sum9;
	logic [1:0]       bcd_h;
	logic [7:0]       bcd_sub;
	logic [14:0]      tens_prod;
	logic [3:0]       bcd_t;
	logic [6:0]       ones_w;

	c8_mem u_mem (.clk(clk), .arst_n(arst_n), .req(mem_req), .rdata(mem_rdata),
		.ready(mem_ready));
	c8_fb  u_fb  (.clk(clk), .arst_n(arst_n), .req(fb_req), .rdata(fb_rdata));
	c8_rf  u_rf  (.clk(clk), .arst_n(arst_n), .req(rf_req), .rdata(rf_rdata));

	// Handshake and result ports.
	assign busy            = (state_q != S_IDLE) || !mem_ready;
	assign accept          = start && !busy;
	assign done            = (state_q == S_RESP);
	assign program_counter = pc_q;
	assign read_data       = rd_q;
	assign sound_on        = (st_q != 8'h00);
	assign key_wait        = wait_q[4];

	// Opcode fields and derived addresses.
	assign nib   = op_q[15:12];
	assign opx   = op_q[11:8];
	assign opy   = op_q[7:4];
	assign opn   = op_q[3:0];
	assign nn    = op_q[7:0];
	assign nnn   = op_q[11:0];
	assign py    = vy_q[4:0] + {1'b0, cnt_q};
	assign col0  = vx_q[5:3];
	assign col1  = col0 + 3'd1;
	assign fb_a0 = {col0, py};
	assign fb_a1 = {col1, py};
	assign i_cnt = i_q + {8'h00, cnt_q};

	// Conditional skips.
	always_comb begin
		case (nib)
			4'h3:    skip = (vx_q == nn);
			4'h4:    skip = (vx_q != nn);
			4'h5:    skip = (opn == 4'h0) && (vx_q == vy_q);
			4'h9:    skip = (opn == 4'h0) && (vx_q != vy_q);
			4'hE:    skip = ((nn == c8_pkg::NN_SKP) && keys_q[vx_q[3:0]]) ||
				((nn == c8_pkg::NN_SKNP) && !keys_q[vx_q[3:0]]);
			default: skip = 1'b0;
		endcase
	end
	assign pc_next = pc_q + (skip ? 12'd4 : 12'd2);

	// Arithmetic and logic of the 8XY_ group.
	assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};
	always_comb begin
		alu_we   = 1'b1;
		alu_flag = 1'b0;
		alu_res  = vy_q;
		case (opn)
			c8_pkg::ALU_MOV: alu_res = vy_q;
			c8_pkg::ALU_OR:  alu_res = vx_q | vy_q;
			c8_pkg::ALU_AND: alu_res = vx_q & vy_q;
			c8_pkg::ALU_XOR: alu_res = vx_q ^ vy_q;
			c8_pkg::ALU_ADD: begin
				alu_res  = sum9[7:0];
				alu_flag = sum9[8];
			end
			c8_pkg::ALU_SUB: begin
				alu_res  = vx_q - vy_q;
				alu_flag = (vx_q >= vy_q);
			end
			c8_pkg::ALU_SHR: begin
				alu_res  = {1'b0, vx_q[7:1]};
				alu_flag = vx_q[0];
			end
			c8_pkg::ALU_SBN: begin
				alu_res  = vy_q - vx_q;
				alu_flag = (vy_q >= vx_q);
			end
			c8_pkg::ALU_SHL: begin
				alu_res  = {vx_q[6:0], 1'b0};
				alu_flag = vx_q[7];
			end
			default: alu_we = 1'b0;
		endcase
	end
	wire alu_has_flag = (opn == c8_pkg::ALU_ADD) || (opn == c8_pkg::ALU_SUB) ||
		(opn == c8_pkg::ALU_SHR) || (opn == c8_pkg::ALU_SBN) ||
		(opn == c8_pkg::ALU_SHL);

	// Decimal digits: hundreds by compare, tens by reciprocal multiply.
	assign bcd_h     = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
	assign bcd_sub   = vx_q - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
	assign tens_prod = {8'h00, rem_q} * 15'd205;
	assign bcd_t     = tens_prod[14:11];
	assign ones_w    = rem_q - 7'({3'b000, bcd_t} * 7'd10);

	// Main memory port selection.
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = pc_q;
		mem_req.wdata = write_data;
		case (state_q)
			S_IDLE: begin
				if (accept && (func == c8_pkg::FN_MEMWR)) begin
					mem_req.we   = 1'b1;
					mem_req.addr = address;
				end
			end
			S_F1: mem_req.addr = pc_q + 12'd1;
			S_EX: begin
				if (nib == 4'h0) begin
					mem_req.addr = sp_q;
				end else if (nib == 4'h2) begin
					mem_req.we    = 1'b1;
					mem_req.addr  = sp_q + 12'd2;
					mem_req.wdata = {4'h0, pc_q[11:8]};
				end else if ((nib == 4'hF) && (nn == c8_pkg::NN_BCD)) begin
					mem_req.we    = 1'b1;
					mem_req.addr  = i_q;
					mem_req.wdata = {6'h00, bcd_h};
				end
			end
			S_RET1: mem_req.addr = sp_q + 12'd1;
			S_CALL: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = sp_q + 12'd1;
				mem_req.wdata = pc_q[7:0];
			end
			S_DMEM, S_LD0: mem_req.addr = i_cnt;
			S_BCD1: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = i_q + 12'd1;
				mem_req.wdata = {4'h0, bcd_t};
			end
			S_BCD2: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = i_q + 12'd2;
				mem_req.wdata = {4'h0, ones_w[3:0]};
			end
			S_ST1: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = i_cnt;
				mem_req.wdata = rf_rdata;
			end
			default: mem_req.addr = pc_q;
		endcase
	end

	// Display store port selection.
	always_comb begin
		fb_req.we    = 1'b0;
		fb_req.clear = (state_q == S_EX) && (op_q == c8_pkg::OP_CLS);
		fb_req.waddr = fb_a0;
		fb_req.wdata = fb_rdata ^ spr_q[7:0];
		fb_req.raddr = address[7:0];
		case (state_q)
			S_DLINE: fb_req.raddr = fb_a0;
			S_DB0: begin
				fb_req.we    = 1'b1;
				fb_req.raddr = fb_a1;
			end
			S_DB1: begin
				fb_req.we    = 1'b1;
				fb_req.waddr = fb_a1;
				fb_req.wdata = fb_rdata ^ spr_q[15:8];
			end
			default: fb_req.raddr = address[7:0];
		endcase
	end

	// Register file port selection.
	always_comb begin
		rf_req.we    = 1'b0;
		rf_req.waddr = opx;
		rf_req.wdata = alu_res;
		rf_req.raddr = opx;
		case (state_q)
			S_IDLE: begin
				if (accept && (func == c8_pkg::FN_KEYDN) && wait_q[4]) begin
					rf_req.we    = 1'b1;
					rf_req.waddr = wait_q[3:0];
					rf_req.wdata = {4'h0, key_index};
				end
			end
			S_RX: rf_req.raddr = (nib == 4'hB) ? 4'h0 : opy;
			S_EX: begin
				case (nib)
					4'h6: begin
						rf_req.we    = 1'b1;
						rf_req.wdata = nn;
					end
					4'h7: begin
						rf_req.we    = 1'b1;
						rf_req.wdata = vx_q + nn;
					end
					4'h8: rf_req.we = alu_we;
					4'hC: begin
						rf_req.we    = 1'b1;
						rf_req.wdata = rnd_q & nn;
					end
					4'hF: begin
						rf_req.we    = (nn == c8_pkg::NN_GDT);
						rf_req.wdata = dt_q;
					end
					default: rf_req.we = 1'b0;
				endcase
			end
			S_FLAG: begin
				rf_req.we    = 1'b1;
				rf_req.waddr = c8_pkg::REG_VF;
				rf_req.wdata = {7'h00, flag_q};
			end
			S_ST0: rf_req.raddr = cnt_q;
			S_LD1: begin
				rf_req.we    = 1'b1;
				rf_req.waddr = cnt_q;
				rf_req.wdata = mem_rdata;
			end
			default: rf_req.we = 1'b0;
		endcase
	end

	// Sequencer and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= c8_pkg::PC_RESET;
			i_q     <= '0;
			sp_q    <= c8_pkg::SP_RESET;
			dt_q    <= '0;
			st_q    <= '0;
			keys_q  <= '0;
			wait_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESP;
						case (func)
							c8_pkg::FN_EXEC: state_q <= S_F1;
							c8_pkg::FN_TICK: begin
								if (dt_q != 8'h00) dt_q <= dt_q - 8'd1;
								if (st_q != 8'h00) st_q <= st_q - 8'd1;
							end
							c8_pkg::FN_KEYDN: begin
								keys_q[key_index] <= 1'b1;
								wait_q            <= '0;
							end
							c8_pkg::FN_KEYUP:  keys_q[key_index] <= 1'b0;
							c8_pkg::FN_DISPRD: state_q <= S_FBRD;
							default:           state_q <= S_RESP;
						endcase
					end
				end
				S_FBRD: state_q <= S_RESP;
				S_F1:   state_q <= S_F2;
				S_F2:   state_q <= S_RX;
				S_RX:   state_q <= S_RY;
				S_RY:   state_q <= S_EX;
				S_EX: begin
					state_q <= S_RESP;
					pc_q    <= pc_next;
					cnt_q   <= '0;
					case (nib)
						4'h0: if (op_q == c8_pkg::OP_RET) state_q <= S_RET1;
						4'h1: pc_q <= nnn;
						4'h2: begin
							pc_q    <= pc_q;
							sp_q    <= sp_q + 12'd2;
							state_q <= S_CALL;
						end
						4'h8: if (alu_has_flag) state_q <= S_FLAG;
						4'hA: i_q <= nnn;
						4'hB: pc_q <= nnn + {4'h0, vy_q};
						4'hD: state_q <= (opn == 4'h0) ? S_FLAG : S_DMEM;
						4'hF: begin
							case (nn)
								c8_pkg::NN_WKEY: wait_q  <= {1'b1, opx};
								c8_pkg::NN_SDT:  dt_q    <= vx_q;
								c8_pkg::NN_SST:  st_q    <= vx_q;
								c8_pkg::NN_ADDI: i_q     <= i_q + {4'h0, vx_q};
								c8_pkg::NN_FONT: i_q     <= {6'h00, vx_q[3:0], 2'b00} +
									{8'h00, vx_q[3:0]};
								c8_pkg::NN_BCD:  state_q <= S_BCD1;
								c8_pkg::NN_STR:  state_q <= S_ST0;
								c8_pkg::NN_LDR:  state_q <= S_LD0;
								default:         state_q <= S_RESP;
							endcase
						end
						default: state_q <= S_RESP;
					endcase
				end
				S_RET1: state_q <= S_RET2;
				S_RET2: begin
					pc_q    <= {ret_hi_q, mem_rdata} + 12'd2;
					sp_q    <= sp_q - 12'd2;
					state_q <= S_RESP;
				end
				S_CALL: begin
					pc_q    <= nnn;
					state_q <= S_RESP;
				end
				S_FLAG:  state_q <= S_RESP;
				S_DMEM:  state_q <= S_DLINE;
				S_DLINE: state_q <= S_DB0;
				S_DB0:   state_q <= S_DB1;
				S_DB1: begin
					cnt_q   <= cnt_q + 4'd1;
					state_q <= ((cnt_q + 4'd1) == opn) ? S_FLAG : S_DMEM;
				end
				S_BCD1: state_q <= S_BCD2;
				S_BCD2: state_q <= S_RESP;
				S_ST0:  state_q <= S_ST1;
				S_LD0:  state_q <= S_LD1;
				S_ST1, S_LD1: begin
					if (cnt_q == opx) begin
						state_q <= S_RESP;
					end else begin
						cnt_q   <= cnt_q + 4'd1;
						state_q <= (state_q == S_ST1) ? S_ST0 : S_LD0;
					end
				end
				S_RESP:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the current word.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rd_q  <= 8'h00;
					rnd_q <= random_byte;
				end
			end
			S_FBRD: rd_q          <= fb_rdata;
			S_F1:   op_q[15:8]    <= mem_rdata;
			S_F2:   op_q[7:0]     <= mem_rdata;
			S_RX:   vx_q          <= rf_rdata;
			S_RY:   vy_q          <= rf_rdata;
			S_EX: begin
				flag_q <= (nib == 4'hD) ? 1'b0 : alu_flag;
				hit_q  <= 1'b0;
				rem_q  <= bcd_sub[6:0];
			end
			S_RET1:  ret_hi_q <= mem_rdata[3:0];
			S_DLINE: spr_q    <= {8'h00, c8_pkg::bit_rev(mem_rdata)} << vx_q[2:0];
			S_DB0:   hit_q    <= hit_q | (|(fb_rdata & spr_q[7:0]));
			S_DB1: begin
				hit_q  <= hit_q | (|(fb_rdata & spr_q[15:8]));
				flag_q <= hit_q | (|(fb_rdata & spr_q[15:8]));
			end
			default: rd_q     <= rd_q;
		endcase
	end

	// The result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	// An accepted word always takes the block out of idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word left block idle");

	// Once filled, the memory never drops back into its fill pass.
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(mem_ready)) else $error("memory fill restarted");

	// A key wait can only begin from an executed instruction.
	a_wait_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_wait) |-> $past(state_q == S_EX))
		else $error("key wait set outside execution");

endmodule

`default_nettype wire
